@@ rtl/core/fidm_pkg.sv @@
package fidm_pkg;

  localparam int unsigned TICK_W   = 32;
  localparam int unsigned BUDGET_W = 31;
  localparam int unsigned STAT_W   = 32;

  // transaction kinds
  localparam logic [1:0] KIND_FRAME      = 2'd0;
  localparam logic [1:0] KIND_READ_SCENE = 2'd1;
  localparam logic [1:0] KIND_READ_TOTAL = 2'd2;

  // statistic selects
  localparam logic [3:0] SEL_SUBMITTED    = 4'd0;
  localparam logic [3:0] SEL_MEASURED     = 4'd1;
  localparam logic [3:0] SEL_MAX_DELTA    = 4'd2;
  localparam logic [3:0] SEL_MISSED       = 4'd3;
  localparam logic [3:0] SEL_OVER_COUNT   = 4'd4;
  localparam logic [3:0] SEL_STREAK       = 4'd5;
  localparam logic [3:0] SEL_MAX_STREAK   = 4'd6;
  localparam logic [3:0] SEL_INV_SCENE    = 4'd7;
  localparam logic [3:0] SEL_INV_INTERVAL = 4'd8;

  // configuration register indexes
  localparam logic CFG_BUDGET    = 1'b0;
  localparam logic CFG_TOLERANCE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_MAX = '1;

  typedef struct packed {
    logic [STAT_W-1:0] submitted;
    logic [STAT_W-1:0] measured;
    logic [STAT_W-1:0] longest_delta;
    logic [STAT_W-1:0] missed_total;
    logic [STAT_W-1:0] over_count;
    logic [STAT_W-1:0] streak;
    logic [STAT_W-1:0] longest_streak;
  } row_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [STAT_W-1:0] sat_inc(input logic [STAT_W-1:0] v);
    return (v == STAT_MAX) ? v : v + STAT_W'(1);
  endfunction

endpackage

@@ rtl/core/fidm_ram.sv @@
module fidm_ram #(
  parameter int unsigned WIDTH = 224,
  parameter int unsigned DEPTH = 9
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/core/fidm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module fidm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [fidm_pkg::TICK_W-1:0]   dividend_i,
  input  logic [fidm_pkg::BUDGET_W-1:0] divisor_i,
  output logic [fidm_pkg::TICK_W-1:0]   quotient_o,
  output fidm_pkg::div_status_t         status_o
);

  localparam int unsigned STEPS = fidm_pkg::TICK_W;
  localparam int unsigned CNT_W = $clog2(STEPS);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [fidm_pkg::TICK_W-1:0]   quo_q;
  logic [fidm_pkg::BUDGET_W-1:0] rem_q;
  logic [fidm_pkg::BUDGET_W-1:0] div_q;

  logic [fidm_pkg::TICK_W-1:0]   rem_sh;
  logic [fidm_pkg::TICK_W-1:0]   rem_diff;
  logic                          fits;

  assign rem_sh   = {rem_q, quo_q[fidm_pkg::TICK_W-1]};
  assign fits     = rem_sh >= {1'b0, div_q};
  assign rem_diff = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(STEPS - 1);
        quo_q  <= dividend_i;
        rem_q  <= '0;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        // remainder stays below the divisor, so the top bit is always clear
        rem_q <= fits ? rem_diff[fidm_pkg::BUDGET_W-1:0] : rem_sh[fidm_pkg::BUDGET_W-1:0];
        quo_q <= {quo_q[fidm_pkg::TICK_W-2:0], fits};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

@@ rtl/core/fidm_row_upd.sv @@
// Next value of one statistics row for a frame transaction.
module fidm_row_upd (
  input  fidm_pkg::row_t                cur_i,
  input  logic                          measure_i,
  input  logic [fidm_pkg::TICK_W-1:0]   delta_i,
  input  logic                          over_i,
  input  logic [fidm_pkg::STAT_W-1:0]   missed_i,
  output fidm_pkg::row_t                nxt_o
);

  logic [fidm_pkg::STAT_W:0]   missed_sum;
  logic [fidm_pkg::STAT_W-1:0] streak_inc;

  assign missed_sum = {1'b0, cur_i.missed_total} + {1'b0, missed_i};
  assign streak_inc = fidm_pkg::sat_inc(cur_i.streak);

  always_comb begin
    nxt_o           = cur_i;
    nxt_o.submitted = fidm_pkg::sat_inc(cur_i.submitted);
    if (measure_i) begin
      nxt_o.measured = fidm_pkg::sat_inc(cur_i.measured);
      if (delta_i > cur_i.longest_delta) begin
        nxt_o.longest_delta = delta_i;
      end
      nxt_o.missed_total = missed_sum[fidm_pkg::STAT_W] ? fidm_pkg::STAT_MAX
                                                        : missed_sum[fidm_pkg::STAT_W-1:0];
      if (over_i) begin
        nxt_o.over_count = fidm_pkg::sat_inc(cur_i.over_count);
        nxt_o.streak     = streak_inc;
        if (streak_inc > cur_i.longest_streak) begin
          nxt_o.longest_streak = streak_inc;
        end
      end else begin
        nxt_o.streak = '0;
      end
    end
  end

endmodule

@@ rtl/core/frame_interval_deadline_monitor.sv @@
// Path from accept to result valid: a measured interval goes through S_PREP, the
// restoring divider and read-modify-write of total and scene rows; a first frame
// or an invalid interval only does the row updates; a row read goes through S_STAT_RD
// and S_STAT_DATA; anything else goes straight to S_FIN. One transaction at a time.
// Reset clears all counters, per-row valid bits and the tick history; budget
// resets to 1 and tolerance to 0. Rows not yet written read as zero.
module frame_interval_deadline_monitor #(
  parameter int unsigned SCENE_COUNT = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [fidm_pkg::BUDGET_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [5:0]                    scene_i,
  input  logic [fidm_pkg::TICK_W-1:0]   frame_tick_i,
  input  logic [3:0]                    stat_select_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          sample_valid_o,
  output logic                          sample_measured_o,
  output logic [fidm_pkg::TICK_W-1:0]   frame_gap_o,
  output logic                          budget_exceeded_o,
  output logic [fidm_pkg::BUDGET_W-1:0] lost_periods_o,
  output logic [fidm_pkg::STAT_W-1:0]   read_value_o
);

  localparam int unsigned ROWS     = SCENE_COUNT + 1;
  localparam int unsigned ROW_W    = $clog2(ROWS);
  localparam int unsigned ROW_BITS = $bits(fidm_pkg::row_t);
  localparam logic [ROW_W-1:0] TOTAL_ROW = ROW_W'(SCENE_COUNT);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_PREP      = 8'b0000_0010,
    S_DIV       = 8'b0000_0100,
    S_ROW_RD    = 8'b0000_1000,
    S_ROW_WR    = 8'b0001_0000,
    S_STAT_RD   = 8'b0010_0000,
    S_STAT_DATA = 8'b0100_0000,
    S_FIN       = 8'b1000_0000
  } state_e;

  state_e                        state_q;
  logic [fidm_pkg::BUDGET_W-1:0] budget_q;
  logic [fidm_pkg::BUDGET_W-1:0] tolerance_q;
  logic                          seen_q;
  logic [fidm_pkg::TICK_W-1:0]   prev_tick_q;
  logic [fidm_pkg::STAT_W-1:0]   inv_scene_q;
  logic [fidm_pkg::STAT_W-1:0]   inv_int_q;
  logic [ROWS-1:0]               row_valid_q;
  logic [ROW_W-1:0]              row_q;
  logic [5:0]                    scene_q;
  logic [3:0]                    sel_q;
  logic                          measure_q;

  logic                          res_sv_q;
  logic                          res_sm_q;
  logic [fidm_pkg::TICK_W-1:0]   res_delta_q;
  logic                          res_over_q;
  logic [fidm_pkg::STAT_W-1:0]   res_missed_q;
  logic [fidm_pkg::STAT_W-1:0]   res_read_q;

  logic                          out_valid_q;
  logic                          out_sv_q;
  logic                          out_sm_q;
  logic [fidm_pkg::TICK_W-1:0]   out_delta_q;
  logic                          out_over_q;
  logic [fidm_pkg::BUDGET_W-1:0] out_missed_q;
  logic [fidm_pkg::STAT_W-1:0]   out_read_q;

  logic [fidm_pkg::BUDGET_W-1:0] budget_eff;
  logic [fidm_pkg::TICK_W-1:0]   tick_delta;
  logic [fidm_pkg::TICK_W-1:0]   dividend;
  logic                          over;
  logic                          scene_bad;
  logic [ROW_W-1:0]              scene_row;
  logic [ROW_W-1:0]              scene_row_q;
  logic                          div_start;
  logic [fidm_pkg::TICK_W-1:0]   quotient;
  fidm_pkg::div_status_t         div_st;
  logic                          ram_we;
  logic [ROW_BITS-1:0]           ram_rdata;
  fidm_pkg::row_t                row_cur;
  fidm_pkg::row_t                row_nxt;
  logic [fidm_pkg::STAT_W-1:0]   stat_value;

  state_e                        acc_state;
  logic                          acc_sv;
  logic                          acc_sm;
  logic                          acc_measure;
  logic [ROW_W-1:0]              acc_row;
  logic [fidm_pkg::STAT_W-1:0]   acc_read;

  // a budget of zero behaves as one
  assign budget_eff  = (budget_q == '0) ? fidm_pkg::BUDGET_W'(1) : budget_q;
  assign tick_delta  = frame_tick_i - prev_tick_q;
  // rounding: add half the budget before the divide
  assign dividend    = res_delta_q + {2'b00, budget_eff[fidm_pkg::BUDGET_W-1:1]};
  assign over        = {1'b0, res_delta_q} > ({2'b00, budget_eff} + {2'b00, tolerance_q});
  assign scene_bad   = {1'b0, scene_i} >= 7'(SCENE_COUNT);
  assign scene_row   = ROW_W'(scene_i);
  assign scene_row_q = ROW_W'(scene_q);
  assign div_start   = state_q == S_PREP;
  assign ram_we      = state_q == S_ROW_WR;
  assign row_cur     = row_valid_q[row_q] ? fidm_pkg::row_t'(ram_rdata) : '0;
  assign in_ready_o  = state_q == S_IDLE;

  fidm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (budget_eff),
    .quotient_o (quotient),
    .status_o   (div_st)
  );

  fidm_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_q),
    .wdata_i (row_nxt),
    .raddr_i (row_q),
    .rdata_o (ram_rdata)
  );

  fidm_row_upd u_row_upd (
    .cur_i     (row_cur),
    .measure_i (measure_q),
    .delta_i   (res_delta_q),
    .over_i    (res_over_q),
    .missed_i  (res_missed_q),
    .nxt_o     (row_nxt)
  );

  always_comb begin
    case (sel_q)
      fidm_pkg::SEL_SUBMITTED:  stat_value = row_cur.submitted;
      fidm_pkg::SEL_MEASURED:   stat_value = row_cur.measured;
      fidm_pkg::SEL_MAX_DELTA:  stat_value = row_cur.longest_delta;
      fidm_pkg::SEL_MISSED:     stat_value = row_cur.missed_total;
      fidm_pkg::SEL_OVER_COUNT: stat_value = row_cur.over_count;
      fidm_pkg::SEL_STREAK:     stat_value = row_cur.streak;
      fidm_pkg::SEL_MAX_STREAK: stat_value = row_cur.longest_streak;
      default:                  stat_value = '0;
    endcase
  end

  // decode of the transaction offered at the input
  always_comb begin
    acc_state   = S_FIN;
    acc_sv      = 1'b0;
    acc_sm      = 1'b0;
    acc_measure = 1'b0;
    acc_row     = TOTAL_ROW;
    acc_read    = '0;
    case (kind_i)
      fidm_pkg::KIND_FRAME: begin
        if (!scene_bad) begin
          acc_state = S_ROW_RD;
          if (!seen_q) begin
            acc_sv = 1'b1;
          end else begin
            acc_sm = 1'b1;
            if (!tick_delta[fidm_pkg::TICK_W-1]) begin
              acc_sv      = 1'b1;
              acc_measure = 1'b1;
              acc_state   = S_PREP;
            end
          end
        end
      end
      fidm_pkg::KIND_READ_SCENE, fidm_pkg::KIND_READ_TOTAL: begin
        if (stat_select_i == fidm_pkg::SEL_INV_SCENE) begin
          acc_read = inv_scene_q;
        end else if (stat_select_i == fidm_pkg::SEL_INV_INTERVAL) begin
          acc_read = inv_int_q;
        end else if (stat_select_i <= fidm_pkg::SEL_MAX_STREAK &&
                     (kind_i == fidm_pkg::KIND_READ_TOTAL || !scene_bad)) begin
          if (kind_i == fidm_pkg::KIND_READ_SCENE) begin
            acc_row = scene_row;
          end
          acc_state = S_STAT_RD;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q    <= fidm_pkg::BUDGET_W'(1);
      tolerance_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fidm_pkg::CFG_BUDGET:    budget_q    <= cfg_wdata_i;
        fidm_pkg::CFG_TOLERANCE: tolerance_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      seen_q       <= 1'b0;
      prev_tick_q  <= '0;
      inv_scene_q  <= '0;
      inv_int_q    <= '0;
      row_valid_q  <= '0;
      row_q        <= '0;
      scene_q      <= '0;
      sel_q        <= '0;
      measure_q    <= 1'b0;
      res_sv_q     <= 1'b0;
      res_sm_q     <= 1'b0;
      res_delta_q  <= '0;
      res_over_q   <= 1'b0;
      res_missed_q <= '0;
      res_read_q   <= '0;
      out_valid_q  <= 1'b0;
      out_sv_q     <= 1'b0;
      out_sm_q     <= 1'b0;
      out_delta_q  <= '0;
      out_over_q   <= 1'b0;
      out_missed_q <= '0;
      out_read_q   <= '0;
    end else begin
      // in S_FIN the output register is reloaded instead
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            res_sv_q     <= acc_sv;
            res_sm_q     <= acc_sm;
            res_delta_q  <= acc_sm ? tick_delta : '0;
            res_over_q   <= 1'b0;
            res_missed_q <= '0;
            res_read_q   <= acc_read;
            scene_q      <= scene_i;
            sel_q        <= stat_select_i;
            measure_q    <= acc_measure;
            row_q        <= acc_row;
            state_q      <= acc_state;
            if (kind_i == fidm_pkg::KIND_FRAME) begin
              if (scene_bad) begin
                inv_scene_q <= fidm_pkg::sat_inc(inv_scene_q);
              end else begin
                prev_tick_q <= frame_tick_i;
                if (!seen_q) begin
                  seen_q <= 1'b1;
                end else if (tick_delta[fidm_pkg::TICK_W-1]) begin
                  inv_int_q <= fidm_pkg::sat_inc(inv_int_q);
                end
              end
            end
          end
        end
        S_PREP: begin
          res_over_q <= over;
          state_q    <= S_DIV;
        end
        S_DIV: begin
          if (div_st.done) begin
            res_missed_q <= (quotient > fidm_pkg::TICK_W'(1)) ?
                            quotient - fidm_pkg::TICK_W'(1) : '0;
            state_q      <= S_ROW_RD;
          end
        end
        S_ROW_RD: begin
          state_q <= S_ROW_WR;
        end
        S_ROW_WR: begin
          row_valid_q[row_q] <= 1'b1;
          // total row first, then the scene row
          if (row_q == TOTAL_ROW) begin
            row_q   <= scene_row_q;
            state_q <= S_ROW_RD;
          end else begin
            state_q <= S_FIN;
          end
        end
        S_STAT_RD: begin
          state_q <= S_STAT_DATA;
        end
        S_STAT_DATA: begin
          res_read_q <= stat_value;
          state_q    <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_sv_q     <= res_sv_q;
            out_sm_q     <= res_sm_q;
            out_delta_q  <= res_delta_q;
            out_over_q   <= res_over_q;
            out_missed_q <= res_missed_q[fidm_pkg::BUDGET_W-1:0];
            out_read_q   <= res_read_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_valid_o    = out_sv_q;
  assign sample_measured_o = out_sm_q;
  assign frame_gap_o       = out_delta_q;
  assign budget_exceeded_o = out_over_q;
  assign lost_periods_o    = out_missed_q;
  assign read_value_o      = out_read_q;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken while busy");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_div_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> state_q == S_DIV)
    else $error("divider running outside the divide state");

  a_ram_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> row_q <= TOTAL_ROW)
    else $error("row write out of range");

  a_over_measured: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (budget_exceeded_o || lost_periods_o != '0)
    |-> sample_valid_o && sample_measured_o)
    else $error("deadline result without a measured interval");

  a_read_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_value_o != '0 |-> !sample_valid_o && !sample_measured_o)
    else $error("read value mixed with frame result");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam int NSCENE = 8;
  localparam int NROWS  = NSCENE + 1;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [3:0] SEL_UNUSED  = 4'd15;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  scene;
    logic [31:0] tick;
    logic [3:0]  sel;
  } frame_req_t;

  typedef struct packed {
    logic        sample_valid;
    logic        sample_measured;
    logic [31:0] delta;
    logic        over;
    logic [30:0] missed;
    logic [31:0] read_value;
  } frame_resp_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_index_i   = 1'b0;
  logic [30:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i        = '0;
  logic [5:0]  scene_i       = '0;
  logic [31:0] frame_tick_i  = '0;
  logic [3:0]  stat_select_i = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic        sample_valid_o;
  logic        sample_measured_o;
  logic [31:0] frame_gap_o;
  logic        budget_exceeded_o;
  logic [30:0] lost_periods_o;
  logic [31:0] read_value_o;

  frame_req_t  pending_q[$];
  frame_resp_t expected_q[$];
  frame_req_t  drv_item;
  frame_resp_t want;
  int unsigned mismatches = 0;
  bit          in_taken   = 1'b0;
  bit          calm       = 1'b0;
  logic [31:0] next_tick  = '0;

  // shadow of the monitor state
  logic [30:0]     budget_sh = 31'd1;
  logic [30:0]     tol_sh    = '0;
  logic [31:0]     last_tick;
  bit              tick_seen;
  fidm_pkg::row_t  rows [NROWS];
  logic [31:0]     bad_scene_cnt;
  logic [31:0]     bad_interval_cnt;

  frame_interval_deadline_monitor #(.SCENE_COUNT(NSCENE)) u_dut (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic void bump_row(int idx, logic [31:0] delta, logic over,
                                   logic [31:0] missed);
    rows[idx].measured = sat_add(rows[idx].measured, 32'd1);
    if (delta > rows[idx].longest_delta) rows[idx].longest_delta = delta;
    rows[idx].missed_total = sat_add(rows[idx].missed_total, missed);
    if (over) begin
      rows[idx].over_count = sat_add(rows[idx].over_count, 32'd1);
      rows[idx].streak = sat_add(rows[idx].streak, 32'd1);
      if (rows[idx].streak > rows[idx].longest_streak)
        rows[idx].longest_streak = rows[idx].streak;
    end else begin
      rows[idx].streak = '0;
    end
  endfunction

  function automatic logic [31:0] row_stat(fidm_pkg::row_t row, logic [3:0] sel);
    case (sel)
      fidm_pkg::SEL_SUBMITTED:  return row.submitted;
      fidm_pkg::SEL_MEASURED:   return row.measured;
      fidm_pkg::SEL_MAX_DELTA:  return row.longest_delta;
      fidm_pkg::SEL_MISSED:     return row.missed_total;
      fidm_pkg::SEL_OVER_COUNT: return row.over_count;
      fidm_pkg::SEL_STREAK:     return row.streak;
      fidm_pkg::SEL_MAX_STREAK: return row.longest_streak;
      default:                  return '0;
    endcase
  endfunction

  function automatic frame_resp_t predict_frame(logic [1:0] k, logic [5:0] sc,
                                                logic [31:0] tick, logic [3:0] sel);
    frame_resp_t r;
    logic [31:0] delta, bud, periods, missed;
    logic        over;
    r = '0;
    if (k == fidm_pkg::KIND_FRAME) begin
      if (sc >= NSCENE) begin
        bad_scene_cnt = sat_add(bad_scene_cnt, 32'd1);
        return r;
      end
      rows[NSCENE].submitted = sat_add(rows[NSCENE].submitted, 32'd1);
      rows[sc].submitted = sat_add(rows[sc].submitted, 32'd1);
      if (!tick_seen) begin
        last_tick = tick;
        tick_seen = 1'b1;
        r.sample_valid = 1'b1;
        return r;
      end
      delta = tick - last_tick;
      last_tick = tick;
      r.sample_measured = 1'b1;
      r.delta = delta;
      if (delta[31]) begin
        bad_interval_cnt = sat_add(bad_interval_cnt, 32'd1);
        return r;
      end
      // a zero budget behaves as one tick
      bud = (budget_sh == '0) ? 32'd1 : 32'(budget_sh);
      over = 33'(delta) > (33'(bud) + 33'(tol_sh));
      periods = (delta + (bud >> 1)) / bud;
      missed = (periods > 32'd1) ? periods - 32'd1 : '0;
      r.sample_valid = 1'b1;
      r.over = over;
      r.missed = missed[30:0];
      bump_row(NSCENE, delta, over, missed);
      bump_row(int'(sc), delta, over, missed);
    end else if (k == fidm_pkg::KIND_READ_SCENE || k == fidm_pkg::KIND_READ_TOTAL) begin
      if (sel == fidm_pkg::SEL_INV_SCENE) r.read_value = bad_scene_cnt;
      else if (sel == fidm_pkg::SEL_INV_INTERVAL) r.read_value = bad_interval_cnt;
      else if (k == fidm_pkg::KIND_READ_TOTAL) r.read_value = row_stat(rows[NSCENE], sel);
      else if (sc < NSCENE) r.read_value = row_stat(rows[sc], sel);
    end
    return r;
  endfunction

  function automatic void push_frame(logic [5:0] sc, logic [31:0] delta);
    frame_req_t it;
    it.kind  = fidm_pkg::KIND_FRAME;
    it.scene = sc;
    it.tick  = next_tick + delta;
    it.sel   = 4'($urandom_range(15));
    // frames on a bad scene leave the tick history alone
    if (sc < NSCENE) next_tick = it.tick;
    pending_q.push_back(it);
  endfunction

  function automatic void push_read(logic [1:0] k, logic [5:0] sc, logic [3:0] sel);
    frame_req_t it;
    it.kind  = k;
    it.scene = sc;
    it.tick  = $urandom;
    it.sel   = sel;
    pending_q.push_back(it);
  endfunction

  // interval aimed at the over-budget edge and the rounding edges, with some invalid, small and random ones
  function automatic logic [31:0] pick_delta();
    longint eff, d;
    int unsigned r;
    eff = (budget_sh == '0) ? 1 : longint'(budget_sh);
    r = $urandom_range(99);
    if (r < 4) return 32'h8000_0000 | $urandom;
    if (r < 10) return $urandom;
    if (r < 20) d = longint'($urandom_range(3));
    else if (r < 60) d = eff + longint'(tol_sh) + longint'($urandom_range(4)) - 2;
    else if (r < 80)
      d = longint'($urandom_range(6)) * eff + eff / 2 + longint'($urandom_range(2)) - 1;
    else d = longint'($urandom) % (3 * (eff + longint'(tol_sh)) + 9);
    if (d < 0) d = 0;
    if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
    return d[31:0];
  endfunction

  function automatic void push_random();
    int unsigned r;
    logic [5:0]  sc;
    logic [3:0]  sel;
    r = $urandom_range(99);
    sel = ($urandom_range(99) < 90) ? 4'($urandom_range(8)) : 4'($urandom_range(15));
    if (r < 62) begin
      sc = ($urandom_range(99) < 88) ? 6'($urandom_range(NSCENE - 1))
                                     : 6'($urandom_range(63, NSCENE));
      push_frame(sc, pick_delta());
    end else if (r < 80) begin
      sc = ($urandom_range(99) < 85) ? 6'($urandom_range(NSCENE - 1))
                                     : 6'($urandom_range(63));
      push_read(fidm_pkg::KIND_READ_SCENE, sc, sel);
    end else if (r < 97) begin
      push_read(fidm_pkg::KIND_READ_TOTAL, 6'($urandom_range(63)), sel);
    end else begin
      push_read(KIND_UNUSED, 6'($urandom_range(63)), 4'($urandom_range(15)));
    end
  endfunction

  // look just after the falling edge, once the driver's updates have landed
  task automatic wait_idle();
    @(negedge clk_i);
    #0.2;
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) begin
      @(negedge clk_i);
      #0.2;
    end
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fidm_pkg::CFG_BUDGET) budget_sh = val;
    else tol_sh = val;
  endtask

  task automatic run_phase(input logic [30:0] budget, input logic [30:0] tol,
                           input int n, input bit quiet);
    wait_idle();
    write_reg(fidm_pkg::CFG_BUDGET, budget);
    write_reg(fidm_pkg::CFG_TOLERANCE, tol);
    calm = quiet;
    repeat (n) push_random();
    wait_idle();
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // driver: new transaction offered on the falling edge
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      in_taken = 1'b0;
      if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
        drv_item = pending_q.pop_front();
        in_valid_i    <= 1'b1;
        kind_i        <= drv_item.kind;
        scene_i       <= drv_item.scene;
        frame_tick_i  <= drv_item.tick;
        stat_select_i <= drv_item.sel;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 28);

  // monitor: results checked, then accepted transactions predicted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got gap %h read %h",
                   $time, frame_gap_o, read_value_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_field("sample_valid", 32'(want.sample_valid), 32'(sample_valid_o));
          check_field("sample_measured", 32'(want.sample_measured),
                      32'(sample_measured_o));
          check_field("frame_gap", want.delta, frame_gap_o);
          check_field("budget_exceeded", 32'(want.over), 32'(budget_exceeded_o));
          check_field("lost_periods", 32'(want.missed), 32'(lost_periods_o));
          check_field("read_value", want.read_value, read_value_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_q.push_back(predict_frame(kind_i, scene_i, frame_tick_i, stat_select_i));
        in_taken = 1'b1;
      end
    end
  end

  initial begin
    last_tick = '0;
    tick_seen = 1'b0;
    bad_scene_cnt = '0;
    bad_interval_cnt = '0;
    foreach (rows[i]) rows[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part, reset configuration (budget 1, no tolerance)
    push_read(fidm_pkg::KIND_READ_TOTAL, 6'd0, fidm_pkg::SEL_SUBMITTED);
    push_frame(6'd8, $urandom);                 // first bad scene index
    push_frame(6'd0, 32'hFFFF_FFF0);            // first frame latches only
    push_frame(6'd7, 32'h0000_0020);            // tick wraps
    repeat (3) push_frame(6'd3, 32'h7FFF_FFFF); // longest valid interval, missed saturates
    push_frame(6'd3, 32'h8000_0000);            // shortest invalid interval
    push_frame(6'd5, 32'hFFFF_FFFF);
    push_frame(6'd5, 32'h0000_0000);            // zero interval breaks the streak
    push_frame(6'd63, 32'h0000_0000);
    push_read(KIND_UNUSED, 6'd63, SEL_UNUSED);
    for (int s = 0; s <= 6; s++) push_read(fidm_pkg::KIND_READ_SCENE, 6'd3, 4'(s));
    push_read(fidm_pkg::KIND_READ_SCENE, 6'd3, SEL_UNUSED);
    push_read(fidm_pkg::KIND_READ_TOTAL, 6'd0, fidm_pkg::SEL_MAX_DELTA);
    push_read(fidm_pkg::KIND_READ_TOTAL, 6'd0, fidm_pkg::SEL_MISSED);
    push_read(fidm_pkg::KIND_READ_TOTAL, 6'd17, fidm_pkg::SEL_INV_SCENE);
    push_read(fidm_pkg::KIND_READ_SCENE, 6'd60, fidm_pkg::SEL_INV_INTERVAL);
    push_read(fidm_pkg::KIND_READ_SCENE, 6'd8, fidm_pkg::SEL_SUBMITTED);
    wait_idle();

    run_phase(31'd1000, 31'd0, 100, 1'b1);
    run_phase(31'd1, 31'h7FFF_FFFF, 80, 1'b0);
    run_phase(31'h7FFF_FFFF, 31'd0, 80, 1'b0);
    run_phase(31'd0, 31'd3, 80, 1'b0);
    run_phase(31'($urandom_range(5000, 1)), 31'($urandom_range(500)), 150, 1'b0);
    run_phase(31'($urandom_range(1 << 20, 1)), 31'($urandom_range(1 << 12)), 150, 1'b0);

    repeat (50) @(negedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
